// File: src/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants for the probe target resolver.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int REG_SLOTS   = 1024;
    localparam int REG_AW      = 10;
    localparam int CACHE_SLOTS = 16384;
    localparam int CACHE_AW    = 14;
    localparam int MIX_SHIFT   = 33;
    localparam logic [63:0] MIX_MUL = 64'hff51afd7ed558ccd;
    localparam logic [11:0] LOW_MASK = 12'hFFF;

    // Cache line: {used, key, target}
    localparam int CLINE_W = 1 + 64 + REG_AW;
    localparam int REGLINE_W = 64 + 16;

    localparam logic OPC_ADD     = 1'b0;
    localparam logic OPC_RESOLVE = 1'b1;

    localparam logic [1:0] ST_ADDED      = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_RESOLVED   = 2'd2;
    localparam logic [1:0] ST_UNRESOLVED = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [63:0] entry_address;
        logic [63:0] image_offset;
        logic [15:0] module_id;
        logic        map_present;
        logic [63:0] map_start;
    } prt_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              low_bits_hit;
        logic [REG_AW-1:0] target_index;
        logic              cache_insert_dropped;
    } prt_res_t;

endpackage

// File: src/probe_target_resolver_core.sv
// ----------------------------------------------------------------------------
// probe_target_resolver_core
// Registry of probe targets with a hashed address cache in front of it.
//
// Input items arrive on the s_* stream. tuser selects the operation: an add
// item appends a target (file offset, module id) to the registry, a resolve
// item looks up an entry address. Each item gives exactly one result item on
// the m_* stream, in order.
// An add writes the registry when it leaves the queue, then loads the output
// register. A resolve leaves the queue, is hashed in S_MUL0 to S_MUL2 and
// S_HOME, then reads and checks one cache slot at a time, then one registry
// entry at a time for each registry scan it needs (exact match, then
// low-12-bit fallback), writes the cache on a registry hit and loads the
// output register, through single-port RAMs and one shared 32x32 multiplier.
// After reset the block sweeps the cache, one slot a cycle, through all 16384
// slots before it starts on the first item; up to two items are queued
// meanwhile. A result waits in the output register while m_tready is low;
// the block keeps working on the next queued item and holds only when that
// one is finished too.
// ----------------------------------------------------------------------------
module probe_target_resolver_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_address[63:0], image_offset[127:64], module_id[143:128],
    // map_start[207:144]
    input  logic [207:0] s_tdata,
    // opcode[0], map_present[1]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // low_bits_hit[0], target_index[10:1], cache_insert_dropped[11], zero pad
    output logic [15:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    logic               q_valid;
    logic               q_pop;
    prt_pkg::prt_item_t q_item;
    prt_pkg::prt_res_t  res;

    prt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    prt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {4'd0, res.cache_insert_dropped, res.target_index, res.low_bits_hit};
    assign m_tuser = res.status;

endmodule

// File: src/prt_ram.sv
// ----------------------------------------------------------------------------
// prt_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: src/prt_front.sv
// ----------------------------------------------------------------------------
// prt_front
// Input side: unpacks accepted items and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module prt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [207:0]      s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              q_valid,
    output prt_pkg::prt_item_t q_item,
    input  logic              q_pop
);

    prt_pkg::prt_item_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    prt_pkg::prt_item_t in_item;
    logic               push;
    logic               pop;

    always_comb
    begin
        in_item.opcode        = s_tuser[0];
        in_item.map_present   = s_tuser[1];
        in_item.entry_address = s_tdata[63:0];
        in_item.image_offset  = s_tdata[127:64];
        in_item.module_id     = s_tdata[143:128];
        in_item.map_start     = s_tdata[207:144];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: src/prt_back.sv
// ----------------------------------------------------------------------------
// prt_back
// Execution side: registry append, hashed cache probe, registry scans,
// cache insert and the output register.
// ----------------------------------------------------------------------------
module prt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  prt_pkg::prt_item_t q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output prt_pkg::prt_res_t  out_res
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_MUL0   = 4'd2;
    localparam logic [3:0] S_MUL1   = 4'd3;
    localparam logic [3:0] S_MUL2   = 4'd4;
    localparam logic [3:0] S_HOME   = 4'd5;
    localparam logic [3:0] S_PRB_RD = 4'd6;
    localparam logic [3:0] S_PRB_CK = 4'd7;
    localparam logic [3:0] S_EX_RD  = 4'd8;
    localparam logic [3:0] S_EX_CK  = 4'd9;
    localparam logic [3:0] S_FB_RD  = 4'd10;
    localparam logic [3:0] S_FB_CK  = 4'd11;
    localparam logic [3:0] S_INS    = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    localparam int CAW = prt_pkg::CACHE_AW;
    localparam int RAW = prt_pkg::REG_AW;

    logic [3:0]          state_reg, state_next;
    logic [CAW-1:0]      clr_reg, clr_next;
    logic [CAW-1:0]      slot_reg, slot_next;
    logic [CAW-1:0]      probes_reg, probes_next;
    logic [CAW-1:0]      ins_slot_reg, ins_slot_next;
    logic                ins_ok_reg, ins_ok_next;
    logic [RAW:0]        count_reg, count_next;
    logic [RAW-1:0]      idx_reg, idx_next;
    logic [RAW-1:0]      hit_reg, hit_next;
    logic                fb_reg, fb_next;
    logic                have_reg, have_next;
    logic                amb_reg, amb_next;
    logic [63:0]         cand_off_reg, cand_off_next;
    logic [15:0]         cand_mod_reg, cand_mod_next;
    logic [63:0]         mix_reg, mix_next;
    logic [63:0]         acc_reg, acc_next;
    logic [63:0]         want_reg, want_next;
    logic [63:0]         addr_reg, addr_next;
    logic [15:0]         mod_reg, mod_next;
    logic                map_reg, map_next;
    prt_pkg::prt_res_t   res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    prt_pkg::prt_res_t   out_res_reg, out_res_next;

    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;
    logic [63:0]         hashed;

    logic                      c_we;
    logic [CAW-1:0]            c_addr;
    logic [prt_pkg::CLINE_W-1:0] c_wdata, c_rdata;
    logic                      r_we;
    logic [RAW-1:0]            r_addr;
    logic [prt_pkg::REGLINE_W-1:0] r_wdata, r_rdata;

    logic                c_used;
    logic [63:0]         c_key;
    logic [RAW-1:0]      c_tgt;
    logic [63:0]         r_off;
    logic [15:0]         r_mod;
    logic                scan_last;

    prt_ram #(.WIDTH(prt_pkg::CLINE_W), .DEPTH(prt_pkg::CACHE_SLOTS)) u_cache (
        .clk   (clk),
        .we    (c_we),
        .addr  (c_addr),
        .wdata (c_wdata),
        .rdata (c_rdata)
    );

    prt_ram #(.WIDTH(prt_pkg::REGLINE_W), .DEPTH(prt_pkg::REG_SLOTS)) u_registry (
        .clk   (clk),
        .we    (r_we),
        .addr  (r_addr),
        .wdata (r_wdata),
        .rdata (r_rdata)
    );

    assign c_used = c_rdata[prt_pkg::CLINE_W-1];
    assign c_key  = c_rdata[RAW+63:RAW];
    assign c_tgt  = c_rdata[RAW-1:0];
    assign r_off  = r_rdata[79:16];
    assign r_mod  = r_rdata[15:0];
    assign scan_last = (({1'b0, idx_reg} + (RAW+1)'(1)) == count_reg);

    // Shared 32x32 multiplier; the low 64 bits of the 64x64 product are
    // accumulated over the states S_MUL0, S_MUL1 and S_MUL2.
    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mul_a = mix_reg[63:32];
                mul_b = prt_pkg::MIX_MUL[31:0];
            end
            S_MUL2:
            begin
                mul_a = mix_reg[31:0];
                mul_b = prt_pkg::MIX_MUL[63:32];
            end
            default:
            begin
                mul_a = mix_reg[31:0];
                mul_b = prt_pkg::MIX_MUL[31:0];
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign hashed = acc_reg ^ (acc_reg >> prt_pkg::MIX_SHIFT);

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        slot_next      = slot_reg;
        probes_next    = probes_reg;
        ins_slot_next  = ins_slot_reg;
        ins_ok_next    = ins_ok_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        fb_next        = fb_reg;
        have_next      = have_reg;
        amb_next       = amb_reg;
        cand_off_next  = cand_off_reg;
        cand_mod_next  = cand_mod_reg;
        mix_next       = mix_reg;
        acc_next       = acc_reg;
        want_next      = want_reg;
        addr_next      = addr_reg;
        mod_next       = mod_reg;
        map_next       = map_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        q_pop          = 1'b0;
        c_we           = 1'b0;
        c_addr         = slot_reg;
        c_wdata        = '0;
        r_we           = 1'b0;
        r_addr         = idx_reg;
        r_wdata        = {q_item.image_offset, q_item.module_id};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                c_we   = 1'b1;
                c_addr = clr_reg;
                clr_next = clr_reg + CAW'(1);
                if (clr_reg == CAW'(prt_pkg::CACHE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    addr_next  = q_item.entry_address;
                    mod_next   = q_item.module_id;
                    map_next   = q_item.map_present;
                    mix_next   = q_item.entry_address ^
                                 (q_item.entry_address >> prt_pkg::MIX_SHIFT);
                    want_next  = q_item.entry_address - q_item.map_start
                                 + q_item.image_offset;
                    res_next   = '0;
                    if (q_item.opcode == prt_pkg::OPC_ADD)
                    begin
                        if (count_reg < (RAW+1)'(prt_pkg::REG_SLOTS))
                        begin
                            r_we   = 1'b1;
                            r_addr = count_reg[RAW-1:0];
                            count_next = count_reg + (RAW+1)'(1);
                            res_next.status = prt_pkg::ST_ADDED;
                            res_next.target_index = count_reg[RAW-1:0];
                        end
                        else
                        begin
                            res_next.status = prt_pkg::ST_FULL;
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MUL0;
                    end
                end
            end
            S_MUL0:
            begin
                acc_next   = mul_p;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                acc_next   = acc_reg + {mul_p[31:0], 32'd0};
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                acc_next   = acc_reg + {mul_p[31:0], 32'd0};
                state_next = S_HOME;
            end
            S_HOME:
            begin
                slot_next   = hashed[CAW-1:0];
                probes_next = '0;
                state_next  = S_PRB_RD;
            end
            S_PRB_RD:
            begin
                state_next = S_PRB_CK;
            end
            S_PRB_CK:
            begin
                idx_next  = '0;
                have_next = 1'b0;
                amb_next  = 1'b0;
                if (!c_used || c_key != addr_reg)
                begin
                    if (!c_used || probes_reg == CAW'(prt_pkg::CACHE_SLOTS - 1))
                    begin
                        // Miss: remember where an insert would land.
                        ins_slot_next = slot_reg;
                        ins_ok_next   = !c_used;
                        if (count_reg == '0)
                        begin
                            res_next.status = prt_pkg::ST_UNRESOLVED;
                            state_next = S_FIN;
                        end
                        else if (map_reg)
                        begin
                            state_next = S_EX_RD;
                        end
                        else
                        begin
                            state_next = S_FB_RD;
                        end
                    end
                    else
                    begin
                        slot_next   = slot_reg + CAW'(1);
                        probes_next = probes_reg + CAW'(1);
                        state_next  = S_PRB_RD;
                    end
                end
                else
                begin
                    res_next.status = prt_pkg::ST_RESOLVED;
                    res_next.target_index = c_tgt;
                    state_next = S_FIN;
                end
            end
            S_EX_RD:
            begin
                state_next = S_EX_CK;
            end
            S_EX_CK:
            begin
                if (r_off == want_reg && r_mod == mod_reg)
                begin
                    hit_next   = idx_reg;
                    fb_next    = 1'b0;
                    state_next = S_INS;
                end
                else if (scan_last)
                begin
                    idx_next   = '0;
                    state_next = S_FB_RD;
                end
                else
                begin
                    idx_next   = idx_reg + RAW'(1);
                    state_next = S_EX_RD;
                end
            end
            S_FB_RD:
            begin
                state_next = S_FB_CK;
            end
            S_FB_CK:
            begin
                if ((r_off[11:0] & prt_pkg::LOW_MASK) == (addr_reg[11:0] & prt_pkg::LOW_MASK))
                begin
                    if (!have_reg)
                    begin
                        have_next     = 1'b1;
                        hit_next      = idx_reg;
                        cand_off_next = r_off;
                        cand_mod_next = r_mod;
                    end
                    else if (r_off != cand_off_reg || r_mod != cand_mod_reg)
                    begin
                        amb_next = 1'b1;
                    end
                end
                if (scan_last)
                begin
                    if (have_next && !amb_next)
                    begin
                        fb_next    = 1'b1;
                        state_next = S_INS;
                    end
                    else
                    begin
                        res_next.status = prt_pkg::ST_UNRESOLVED;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + RAW'(1);
                    state_next = S_FB_RD;
                end
            end
            S_INS:
            begin
                c_we    = ins_ok_reg;
                c_addr  = ins_slot_reg;
                c_wdata = {1'b1, addr_reg, hit_reg};
                res_next.status = prt_pkg::ST_RESOLVED;
                res_next.low_bits_hit = fb_reg;
                res_next.target_index = hit_reg;
                res_next.cache_insert_dropped = !ins_ok_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        probes_reg   <= probes_next;
        ins_slot_reg <= ins_slot_next;
        ins_ok_reg   <= ins_ok_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        fb_reg       <= fb_next;
        have_reg     <= have_next;
        amb_reg      <= amb_next;
        cand_off_reg <= cand_off_next;
        cand_mod_reg <= cand_mod_next;
        mix_reg      <= mix_next;
        acc_reg      <= acc_next;
        want_reg     <= want_next;
        addr_reg     <= addr_next;
        mod_reg      <= mod_next;
        map_reg      <= map_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: verif/probe_target_resolver_checker.sv
// ----------------------------------------------------------------------------
// probe_target_resolver_checker
// Watches both streams of the probe target resolver, predicts each result
// from its own copy of the registry and the address cache, and compares.
// ----------------------------------------------------------------------------
module probe_target_resolver_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [207:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [15:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           pending
);

    bit                 slot_used [prt_pkg::CACHE_SLOTS];
    logic [63:0]        slot_addr [prt_pkg::CACHE_SLOTS];
    logic [9:0]         slot_tgt  [prt_pkg::CACHE_SLOTS];
    logic [63:0]        tgt_offset [prt_pkg::REG_SLOTS];
    logic [15:0]        tgt_module [prt_pkg::REG_SLOTS];
    int                 tgt_count;
    prt_pkg::prt_res_t  results_due [$];

    function automatic logic [prt_pkg::CACHE_AW-1:0] home_slot(logic [63:0] key);
        logic [63:0] v;
        v = key ^ (key >> prt_pkg::MIX_SHIFT);
        v = v * prt_pkg::MIX_MUL;
        v = v ^ (v >> prt_pkg::MIX_SHIFT);
        return v[prt_pkg::CACHE_AW-1:0];
    endfunction

    task automatic resolve_item(input logic [207:0] d, input logic [1:0] u);
        logic [63:0]       addr, off, start, want;
        logic [15:0]       modid;
        int                s, hit, cand;
        bit                found, have, ambiguous, cached, dropped;
        prt_pkg::prt_res_t r;
        addr  = d[63:0];
        off   = d[127:64];
        modid = d[143:128];
        start = d[207:144];
        r = '0;
        r.status = prt_pkg::ST_UNRESOLVED;
        found = 0;
        cached = 0;
        hit = 0;
        if (u[0] == prt_pkg::OPC_ADD)
        begin
            if (tgt_count < prt_pkg::REG_SLOTS)
            begin
                tgt_offset[tgt_count] = off;
                tgt_module[tgt_count] = modid;
                r.target_index = tgt_count[prt_pkg::REG_AW-1:0];
                r.status = prt_pkg::ST_ADDED;
                tgt_count++;
            end
            else
                r.status = prt_pkg::ST_FULL;
        end
        else
        begin
            s = int'(home_slot(addr));
            for (int n = 0; n < prt_pkg::CACHE_SLOTS && slot_used[s]; n++)
            begin
                if (slot_addr[s] == addr)
                begin
                    cached = 1;
                    hit = int'(slot_tgt[s]);
                    break;
                end
                s = (s + 1) % prt_pkg::CACHE_SLOTS;
            end
            if (cached)
            begin
                r.status = prt_pkg::ST_RESOLVED;
                r.target_index = hit[prt_pkg::REG_AW-1:0];
            end
            else
            begin
                if (u[1])
                begin
                    want = addr - start + off;
                    for (int i = 0; i < tgt_count; i++)
                        if (tgt_offset[i] == want && tgt_module[i] == modid)
                        begin
                            hit = i;
                            found = 1;
                            break;
                        end
                end
                if (!found)
                begin
                    have = 0;
                    ambiguous = 0;
                    cand = 0;
                    for (int i = 0; i < tgt_count && !ambiguous; i++)
                    begin
                        if (tgt_offset[i][11:0] != addr[11:0])
                            continue;
                        if (!have)
                        begin
                            have = 1;
                            cand = i;
                        end
                        else if (tgt_offset[i] != tgt_offset[cand] ||
                                 tgt_module[i] != tgt_module[cand])
                            ambiguous = 1;
                    end
                    if (have && !ambiguous)
                    begin
                        hit = cand;
                        found = 1;
                        r.low_bits_hit = 1;
                    end
                end
                if (found)
                begin
                    // Insert overwrites a slot holding the same key.
                    dropped = 1;
                    s = int'(home_slot(addr));
                    for (int n = 0; n < prt_pkg::CACHE_SLOTS; n++)
                    begin
                        if (!slot_used[s] || slot_addr[s] == addr)
                        begin
                            slot_used[s] = 1;
                            slot_addr[s] = addr;
                            slot_tgt[s]  = hit[prt_pkg::REG_AW-1:0];
                            dropped = 0;
                            break;
                        end
                        s = (s + 1) % prt_pkg::CACHE_SLOTS;
                    end
                    r.cache_insert_dropped = dropped;
                    r.status = prt_pkg::ST_RESOLVED;
                    r.target_index = hit[prt_pkg::REG_AW-1:0];
                end
            end
        end
        results_due.push_back(r);
    endtask

    task automatic check_result();
        prt_pkg::prt_res_t e;
        if (results_due.size() == 0)
        begin
            $error("result item with no expectation: status=%0d data=%h", m_tuser, m_tdata);
            errors++;
            return;
        end
        e = results_due.pop_front();
        if (m_tuser != e.status)
        begin
            $error("status: expected %0d, actual %0d", e.status, m_tuser);
            errors++;
        end
        if (m_tdata[0] != e.low_bits_hit)
        begin
            $error("low_bits_hit: expected %0d, actual %0d", e.low_bits_hit, m_tdata[0]);
            errors++;
        end
        if (m_tdata[10:1] != e.target_index)
        begin
            $error("target_index: expected %0d, actual %0d", e.target_index, m_tdata[10:1]);
            errors++;
        end
        if (m_tdata[11] != e.cache_insert_dropped)
        begin
            $error("cache_insert_dropped: expected %0d, actual %0d",
                   e.cache_insert_dropped, m_tdata[11]);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        tgt_count = 0;
        foreach (slot_used[i])
            slot_used[i] = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                resolve_item(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                check_result();
            pending = results_due.size();
        end
    end

endmodule

// File: verif/probe_target_resolver_core_tb.sv
// ----------------------------------------------------------------------------
// probe_target_resolver_core_tb
// Drives add and resolve items into the resolver: a directed opening, then
// random traffic built mostly from lookups that should hit (exact mapping,
// low-bit fallback, cached repeats). Both streams idle at random; the
// checker predicts every result.
// ----------------------------------------------------------------------------
module probe_target_resolver_core_tb;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           pending;

    logic [63:0]  known_off [$];
    logic [15:0]  known_mod [$];
    logic [63:0]  known_addr [$];
    int           added;
    bit           no_idle;
    int           stall_left;

    probe_target_resolver_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    probe_target_resolver_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // The receiver stalls at random, in short and occasional long runs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left <= idle_len();
        end
    end

    task automatic send_item(input logic op, input logic [63:0] addr, input logic [63:0] off,
                             input logic [15:0] modid, input logic mp, input logic [63:0] start);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {start, modid, off, addr};
        s_tuser  <= {mp, op};
        do
            @(posedge clk);
        while (!s_tready);
        if (op == prt_pkg::OPC_ADD)
        begin
            if (added < prt_pkg::REG_SLOTS)
            begin
                known_off.push_back(off);
                known_mod.push_back(modid);
            end
            added++;
        end
        else
            known_addr.push_back(addr);
    endtask

    task automatic add_target(input logic [63:0] off, input logic [15:0] modid);
        send_item(prt_pkg::OPC_ADD, rand64(), off, modid, 1'($urandom_range(0, 1)), rand64());
    endtask

    // Lookup through a mapping that places the target's offset at the address.
    task automatic resolve_exact(input int i);
        logic [63:0] start, moff;
        start = rand64();
        moff  = rand64();
        send_item(prt_pkg::OPC_RESOLVE, known_off[i] - moff + start, moff, known_mod[i], 1'b1,
                  start);
    endtask

    task automatic resolve_low_bits(input int i);
        logic [63:0] a;
        a = rand64();
        a[11:0] = known_off[i][11:0];
        send_item(prt_pkg::OPC_RESOLVE, a, rand64(), 16'($urandom),
                  1'($urandom_range(0, 1)), rand64());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int k;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        added    = 0;
        no_idle  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening.
        send_item(prt_pkg::OPC_RESOLVE, 64'h0, 64'h0, 16'h0, 1'b1, 64'h0);
        add_target(64'h0, 16'h0);
        add_target('1, 16'hFFFF);
        add_target(64'h0000_0000_0040_1123, 16'h0007);
        add_target(64'h0000_0000_0040_1123, 16'h0007);
        resolve_exact(0);
        resolve_exact(1);
        send_item(prt_pkg::OPC_RESOLVE, '1, 64'h1, 16'hFFFF, 1'b1, 64'h0);
        send_item(prt_pkg::OPC_RESOLVE, 64'h7FFF_0000_0000_5123, 64'h0, 16'h1234, 1'b1, 64'h0);
        send_item(prt_pkg::OPC_RESOLVE, 64'hFFFF_FFFF_FFFF_F123, '1, 16'h0, 1'b0, '1);
        resolve_exact(2);
        send_item(prt_pkg::OPC_RESOLVE, known_addr[1], 64'h0, 16'h0, 1'b0, 64'h0);
        add_target(64'h0000_0000_0080_2123, 16'h0007);
        send_item(prt_pkg::OPC_RESOLVE, 64'h1234_0000_0000_0123, 64'h0, 16'h0, 1'b0, 64'h0);
        send_item(prt_pkg::OPC_RESOLVE, 64'h5555_0000_0000_0123, 64'h0, 16'h0, 1'b1, 64'h0);
        resolve_exact(4);
        send_item(prt_pkg::OPC_RESOLVE, known_addr[0], rand64(), 16'($urandom), 1'b1, rand64());
        add_target(64'hAAAA_5555_AAAA_5555, 16'h5555);
        add_target(64'h5555_AAAA_5555_AAAA, 16'hAAAA);
        resolve_low_bits(5);
        resolve_low_bits(6);
        send_item(prt_pkg::OPC_RESOLVE, known_addr[$], 64'h0, 16'h0, 1'b0, 64'h0);

        // Random traffic, mostly lookups that reach a target.
        for (int n = 0; n < 600; n++)
        begin
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            k = $urandom_range(0, 99);
            if (k < 22)
                add_target(rand64(), 16'($urandom));
            else if (k < 50)
                resolve_exact($urandom_range(0, known_off.size() - 1));
            else if (k < 68)
                resolve_low_bits($urandom_range(0, known_off.size() - 1));
            else if (k < 88)
                send_item(prt_pkg::OPC_RESOLVE,
                          known_addr[$urandom_range(0, known_addr.size() - 1)],
                          rand64(), 16'($urandom), 1'($urandom_range(0, 1)), rand64());
            else
                send_item(prt_pkg::OPC_RESOLVE, rand64(), rand64(), 16'($urandom),
                          1'($urandom_range(0, 1)), rand64());
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
